@@ hdl/vgo_pkg.sv @@
package vgo_pkg;

  // default geometry
  localparam int PHASE_BITS_DEF      = 16;
  localparam int SINE_TABLE_BITS_DEF = 10;

  // field and register widths
  localparam int TRIG_W     = 16;
  localparam int SAMPLE_W   = 15;
  localparam int SINE_W     = 16;
  localparam int INC_W      = 15;
  localparam int LIMIT_W    = 9;
  localparam int DECAY_W    = 12;
  localparam int AMP_W      = 17;
  localparam int COUNT_W    = 10;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 15;

  // shared multiplier operand and product widths
  localparam int MUL_A_W = 30;
  localparam int MUL_B_W = 17;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_INC   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CYCLE_LIMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY       = 2'd2;

  // reset values
  localparam logic [INC_W-1:0]   PHASE_INC_RST   = 15'd3072;
  localparam logic [LIMIT_W-1:0] CYCLE_LIMIT_RST = 9'd32;
  localparam logic [DECAY_W-1:0] DECAY_RST       = 12'd2048;
  localparam logic [AMP_W-1:0]   AMP_ONE         = 17'h10000;
  localparam logic [COUNT_W-1:0] COUNT_MAX       = 10'd1023;
  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX     = 15'h7fff;

  // polynomial coefficients of the quarter-wave sine approximation
  localparam longint unsigned SIN_A = 51472;
  localparam longint unsigned SIN_B = 21155;
  localparam longint unsigned SIN_C = 2451;

  // quarter-wave sine of x in Q15 (0..32768), clamped to 32767
  function automatic logic [SAMPLE_W-1:0] quarter_wave(input longint unsigned x);
    longint unsigned x2;
    longint unsigned t;
    x2 = (x * x) >> 15;
    t  = SIN_B - ((SIN_C * x2) >> 15);
    t  = SIN_A - ((t * x2) >> 15);
    t  = (t * x) >> 15;
    return (t > 32767) ? SAMPLE_MAX : t[SAMPLE_W-1:0];
  endfunction

endpackage

@@ hdl/vosim_grain_oscillator.sv @@
// Sequence: an idle-state item goes straight to FINISH; a running one passes SQUARE, SCALE,
//   HOLD, then DECAY and DECAY_WB once per sine crossing (at most two per item), then FINISH.
// Items: a new item is taken only in IDLE, so one item is in flight at a time; the single
//   shared multiplier serves square, amplitude scaling and decay in turn.
// Reset: rst_n is synchronous, active low; it restores the configuration defaults,
//   clears the oscillator state (amplitude to unity) and empties the output register.
module vosim_grain_oscillator
  import vgo_pkg::*;
#(
  parameter int PHASE_BITS      = PHASE_BITS_DEF,
  parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [15:0]           in_tdata,   // [15:0] trigger_sample
  // result stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [15:0]           out_tdata,  // [14:0] output_sample, [15] zero
  // configuration writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int ROM_DEPTH = 1 << SINE_TABLE_BITS;
  localparam int QUARTER   = 1 << (SINE_TABLE_BITS - 2);
  localparam int W_SHIFT   = 15 - (SINE_TABLE_BITS - 2);

  typedef logic signed [SINE_W-1:0] rom_t [ROM_DEPTH];

  function automatic rom_t build_rom();
    rom_t                     rom;
    int                       quad;
    longint unsigned          w;
    longint unsigned          x;
    logic signed [SINE_W-1:0] v;
    for (int i = 0; i < ROM_DEPTH; i++) begin
      quad   = (i >> (SINE_TABLE_BITS - 2)) & 3;
      w      = longint'(i & (QUARTER - 1)) << W_SHIFT;
      x      = quad[0] ? (64'd32768 - w) : w;
      v      = {1'b0, quarter_wave(x)};
      rom[i] = quad[1] ? -v : v;
    end
    return rom;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_SCALE,
    ST_HOLD,
    ST_DECAY,
    ST_DECAY_WB,
    ST_FINISH
  } state_t;

  state_t state_r, state_nxt;

  // configuration
  logic [INC_W-1:0]   phase_inc_r,   phase_inc_nxt;
  logic [LIMIT_W-1:0] cycle_limit_r, cycle_limit_nxt;
  logic [DECAY_W-1:0] decay_r,       decay_nxt;

  // oscillator state
  logic                      running_r,    running_nxt;
  logic [PHASE_BITS-1:0]     phase_r,      phase_nxt;
  logic [COUNT_W-1:0]        count_r,      count_nxt;
  logic [AMP_W-1:0]          amp_r,        amp_nxt;
  logic signed [SINE_W-1:0]  prev_sine_r,  prev_sine_nxt;
  logic signed [TRIG_W-1:0]  prev_trig_r,  prev_trig_nxt;
  logic [SAMPLE_W-1:0]       held_r,       held_nxt;
  logic [1:0]                cross_r,      cross_nxt;

  // payload
  logic [SAMPLE_W-1:0]       emit_r,       emit_nxt;
  logic [SAMPLE_W-1:0]       out_sample_r, out_sample_nxt;
  logic                      out_valid_r,  out_valid_nxt;
  logic [MUL_P_W-1:0]        mul_p_r;

  logic signed [SINE_W-1:0]  sine_q;
  logic [SINE_TABLE_BITS-1:0] rom_addr;

  logic [MUL_A_W-1:0]        mul_a;
  logic [MUL_B_W-1:0]        mul_b;

  logic signed [TRIG_W-1:0]  trig;
  logic signed [SINE_W-1:0]  sine_neg;
  logic [SAMPLE_W-1:0]       mag;
  logic                      cross_fall, cross_rise;
  logic                      in_accept;
  logic                      run_step, restart;

  assign rom_addr   = phase_r[PHASE_BITS-1 -: SINE_TABLE_BITS];
  assign trig       = in_tdata;
  assign in_tready  = (state_r == ST_IDLE);
  assign in_accept  = in_tvalid && in_tready;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_sample_r};

  assign run_step = running_r && (count_r <= {1'b0, cycle_limit_r});
  assign restart  = (trig > 0) && (prev_trig_r <= 0);

  assign sine_neg   = -sine_q;
  assign mag        = sine_q[SINE_W-1] ? sine_neg[SAMPLE_W-1:0] : sine_q[SAMPLE_W-1:0];
  assign cross_fall = (prev_sine_r >= 0) && (sine_q <= 0);
  assign cross_rise = (prev_sine_r <= 0) && (sine_q >= 0);

  // sine ROM, registered read
  always_ff @(posedge clk) begin
    sine_q <= SINE_ROM[rom_addr];
  end

  always_comb begin
    state_nxt       = state_r;
    phase_inc_nxt   = phase_inc_r;
    cycle_limit_nxt = cycle_limit_r;
    decay_nxt       = decay_r;
    running_nxt     = running_r;
    phase_nxt       = phase_r;
    count_nxt       = count_r;
    amp_nxt         = amp_r;
    prev_sine_nxt   = prev_sine_r;
    prev_trig_nxt   = prev_trig_r;
    held_nxt        = held_r;
    cross_nxt       = cross_r;
    emit_nxt        = emit_r;
    out_sample_nxt  = out_sample_r;
    out_valid_nxt   = out_valid_r;
    mul_a           = '0;
    mul_b           = '0;

    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_PHASE_INC:   phase_inc_nxt   = cfg_data[INC_W-1:0];
        REG_CYCLE_LIMIT: cycle_limit_nxt = cfg_data[LIMIT_W-1:0];
        REG_DECAY:       decay_nxt       = cfg_data[DECAY_W-1:0];
        default: ;
      endcase
    end

    // drop the result once taken
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          prev_trig_nxt = trig;
          emit_nxt      = held_r;
          state_nxt     = ST_FINISH;
          if (run_step) begin
            state_nxt = ST_SQUARE;
          end else if (restart) begin
            amp_nxt       = AMP_ONE;
            count_nxt     = '0;
            held_nxt      = '0;
            prev_sine_nxt = '0;
            phase_nxt     = PHASE_BITS'(phase_inc_r);
            running_nxt   = 1'b1;
          end else if (count_r >= {1'b0, cycle_limit_r}) begin
            phase_nxt   = '0;
            running_nxt = 1'b0;
          end
        end
      end
      ST_SQUARE: begin
        mul_a         = MUL_A_W'(mag);
        mul_b         = MUL_B_W'(mag);
        cross_nxt     = {1'b0, cross_fall} + {1'b0, cross_rise};
        prev_sine_nxt = sine_q;
        phase_nxt     = phase_r + PHASE_BITS'(phase_inc_r);
        state_nxt     = ST_SCALE;
      end
      ST_SCALE: begin
        mul_a     = mul_p_r[MUL_A_W-1:0];
        mul_b     = amp_r;
        state_nxt = ST_HOLD;
      end
      ST_HOLD: begin
        // saturate (sine^2 * amplitude) >> 31
        held_nxt  = mul_p_r[MUL_P_W-1] ? SAMPLE_MAX : mul_p_r[MUL_P_W-2 -: SAMPLE_W];
        state_nxt = (cross_r != 2'd0) ? ST_DECAY : ST_FINISH;
      end
      ST_DECAY: begin
        mul_a     = MUL_A_W'(amp_r);
        mul_b     = MUL_B_W'(decay_r);
        state_nxt = ST_DECAY_WB;
      end
      ST_DECAY_WB: begin
        amp_nxt   = mul_p_r[AMP_W+11:12];
        count_nxt = (count_r == COUNT_MAX) ? count_r : count_r + 1'b1;
        cross_nxt = cross_r - 1'b1;
        state_nxt = (cross_r == 2'd1) ? ST_FINISH : ST_DECAY;
      end
      ST_FINISH: begin
        // hold until the output register is free
        if (!out_valid_r || out_tready) begin
          out_sample_nxt = emit_r;
          out_valid_nxt  = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    mul_p_r      <= MUL_P_W'(mul_a) * MUL_P_W'(mul_b);
    emit_r       <= emit_nxt;
    out_sample_r <= out_sample_nxt;
    cross_r      <= cross_nxt;
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      phase_inc_r   <= PHASE_INC_RST;
      cycle_limit_r <= CYCLE_LIMIT_RST;
      decay_r       <= DECAY_RST;
      running_r     <= 1'b0;
      phase_r       <= '0;
      count_r       <= '0;
      amp_r         <= AMP_ONE;
      prev_sine_r   <= '0;
      prev_trig_r   <= '0;
      held_r        <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      phase_inc_r   <= phase_inc_nxt;
      cycle_limit_r <= cycle_limit_nxt;
      decay_r       <= decay_nxt;
      running_r     <= running_nxt;
      phase_r       <= phase_nxt;
      count_r       <= count_nxt;
      amp_r         <= amp_nxt;
      prev_sine_r   <= prev_sine_nxt;
      prev_trig_r   <= prev_trig_nxt;
      held_r        <= held_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

endmodule

@@ bench/tb_vosim_grain_oscillator.sv @@
module tb_vosim_grain_oscillator;
  timeunit 1ns;
  timeprecision 1ps;
  import vgo_pkg::*;

  localparam int STALL_LIMIT = 4000;
  localparam int FLUSH_CYCLES = 12;

  // quarter-wave polynomial coefficients, Q15
  localparam longint unsigned POLY_LIN  = 51472;
  localparam longint unsigned POLY_CUB  = 21155;
  localparam longint unsigned POLY_QUIN = 2451;

  localparam logic [TRIG_W-1:0] OPENING [24] = '{
    16'h0000, 16'h8000, 16'h7fff, 16'h7fff, 16'hffff, 16'h0000, 16'h0001, 16'h0000,
    16'hffff, 16'h0001, 16'h0001, 16'h8000, 16'h7fff, 16'h0000, 16'h0000, 16'h0005,
    16'hfffb, 16'h7fff, 16'h8000, 16'h0000, 16'h0001, 16'hffff, 16'h0064, 16'h0000
  };

  class grain_scoreboard;
    logic [INC_W-1:0]         phase_inc;
    logic [LIMIT_W-1:0]       cycle_limit;
    logic [DECAY_W-1:0]       decay;
    logic                     running;
    logic [15:0]              phase;
    logic [COUNT_W-1:0]       half_cycles;
    logic [AMP_W-1:0]         amp;
    logic signed [SINE_W-1:0] last_sine;
    logic signed [TRIG_W-1:0] last_trigger;
    logic [SAMPLE_W-1:0]      held;
    logic [SAMPLE_W-1:0]      expected_samples[$];
    int                       errors;

    function new();
      phase_inc    = PHASE_INC_RST;
      cycle_limit  = CYCLE_LIMIT_RST;
      decay        = DECAY_RST;
      running      = 1'b0;
      phase        = '0;
      half_cycles  = '0;
      amp          = AMP_ONE;
      last_sine    = '0;
      last_trigger = '0;
      held         = '0;
      errors       = 0;
    endfunction

    function int pending();
      return expected_samples.size();
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        REG_PHASE_INC:   phase_inc = value[INC_W-1:0];
        REG_CYCLE_LIMIT: cycle_limit = value[LIMIT_W-1:0];
        REG_DECAY:       decay = value[DECAY_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [SAMPLE_W-1:0] quarter_poly(longint unsigned x);
      longint unsigned x2;
      longint unsigned t;
      x2 = (x * x) >> 15;
      t  = POLY_CUB - ((POLY_QUIN * x2) >> 15);
      t  = POLY_LIN - ((t * x2) >> 15);
      t  = (t * x) >> 15;
      return (t > 32767) ? SAMPLE_MAX : t[SAMPLE_W-1:0];
    endfunction

    // top 10 phase bits address the table; mirror odd quadrants, negate the upper two quadrants
    function int sine_of_phase(logic [15:0] ph);
      logic [9:0]      idx;
      logic [1:0]      quad;
      longint unsigned w;
      longint unsigned x;
      int              v;
      idx  = ph[15:6];
      quad = idx[9:8];
      w    = idx[7:0];
      w    = w << 7;
      x    = quad[0] ? 32768 - w : w;
      v    = int'(quarter_poly(x));
      return quad[1] ? -v : v;
    endfunction

    function void count_crossing();
      logic [63:0] prod;
      if (half_cycles != COUNT_MAX) half_cycles++;
      prod = amp;
      prod = (prod * decay) >> 12;
      amp  = prod[AMP_W-1:0];
    endfunction

    function void take_trigger(logic [TRIG_W-1:0] raw);
      logic signed [TRIG_W-1:0] trig;
      int                       s;
      logic [63:0]              mag;
      logic [63:0]              v;
      trig = raw;
      // the block emits the value held from the previous tick
      expected_samples.push_back(held);
      if (running && half_cycles <= cycle_limit) begin
        s    = sine_of_phase(phase);
        mag  = (s < 0) ? -s : s;
        v    = (mag * mag * amp) >> 31;
        held = (v > 32767) ? SAMPLE_MAX : v[SAMPLE_W-1:0];
        if (last_sine >= 0 && s <= 0) count_crossing();
        if (last_sine <= 0 && s >= 0) count_crossing();
        last_sine = s;
        phase     = phase + phase_inc;
      end else if (trig > 0 && last_trigger <= 0) begin
        amp         = AMP_ONE;
        half_cycles = '0;
        held        = '0;
        last_sine   = '0;
        phase       = {1'b0, phase_inc};
        running     = 1'b1;
      end else if (half_cycles >= cycle_limit) begin
        phase   = '0;
        running = 1'b0;
      end
      last_trigger = trig;
    endfunction

    function void match_sample(logic [15:0] word);
      logic [15:0] want;
      if (expected_samples.size() == 0) begin
        errors++;
        $display("%0t: output_sample with nothing expected: expected none, actual %0d",
                 $time, word);
        return;
      end
      want = {1'b0, expected_samples.pop_front()};
      if (word !== want) begin
        errors++;
        $display("%0t: output_sample mismatch: expected %0d, actual %0d", $time, want, word);
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [15:0]           in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [15:0]           out_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_PHASE_INC;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  bit                    steady = 1'b0;
  int                    stalled = 0;

  grain_scoreboard board = new();

  vosim_grain_oscillator dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // observe every transaction at the edge that completes it
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) board.set_register(cfg_index, cfg_data);
      if (in_tvalid && in_tready) board.take_trigger(in_tdata);
      if (out_tvalid && out_tready) board.match_sample(out_tdata);
    end
    out_tready <= steady || ($urandom_range(0, 99) >= 14);
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      stalled <= 0;
    else
      stalled <= stalled + 1;
    if (stalled >= STALL_LIMIT) begin
      $display("tb_vosim_grain_oscillator: FAIL");
      $finish;
    end
  end

  task automatic push_trigger(input logic [TRIG_W-1:0] value);
    int gap;
    if (!steady && $urandom_range(0, 99) < 14) begin
      in_tvalid <= 1'b0;
      gap = $urandom_range(1, 4);
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= value;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // hold valid high across back-to-back writes; the caller drops it
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // stop sending and wait out every outstanding sample
  task automatic drain_samples();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (board.pending() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic shuffle_settings();
    int pick;
    if ($urandom_range(0, 99) < 60) begin
      pick = $urandom_range(0, 19);
      if (pick == 0)
        write_register(REG_PHASE_INC, 15'd1);
      else if (pick == 1)
        write_register(REG_PHASE_INC, 15'h7fff);
      else if (pick < 4)
        write_register(REG_PHASE_INC, CFG_DATA_W'($urandom_range(2, 2047)));
      else
        write_register(REG_PHASE_INC, CFG_DATA_W'($urandom_range(2048, 32766)));
    end
    if ($urandom_range(0, 99) < 60) begin
      pick = $urandom_range(0, 19);
      if (pick < 2)
        write_register(REG_CYCLE_LIMIT, 15'd0);
      else if (pick == 2)
        write_register(REG_CYCLE_LIMIT, 15'd511);
      else if (pick < 5)
        write_register(REG_CYCLE_LIMIT, CFG_DATA_W'($urandom_range(13, 510)));
      else
        write_register(REG_CYCLE_LIMIT, CFG_DATA_W'($urandom_range(1, 12)));
    end
    if ($urandom_range(0, 99) < 60) begin
      pick = $urandom_range(0, 9);
      if (pick == 0)
        write_register(REG_DECAY, 15'd0);
      else if (pick == 1)
        write_register(REG_DECAY, 15'd4095);
      else
        write_register(REG_DECAY, CFG_DATA_W'($urandom_range(1, 4094)));
    end
    cfg_valid <= 1'b0;
  endtask

  // mostly quiet stretches ending in a rising crossing, with some raw noise
  task automatic play_triggers(input int count);
    int                quiet_left;
    logic [TRIG_W-1:0] value;
    quiet_left = $urandom_range(0, 6);
    for (int n = 0; n < count; n++) begin
      value = $urandom;
      if ($urandom_range(0, 99) >= 20) begin
        if (quiet_left > 0) begin
          value[15] = 1'b1;
          if ($urandom_range(0, 99) < 15) value = '0;
          quiet_left--;
        end else begin
          value[15] = 1'b0;
          if (value == '0) value = 16'h0001;
          quiet_left = $urandom_range(0, 6);
        end
      end
      push_trigger(value);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings, then one extreme corner per group
    for (int i = 0; i < 8; i++) push_trigger(OPENING[i]);
    drain_samples();
    write_register(REG_PHASE_INC, 15'd1);
    write_register(REG_CYCLE_LIMIT, 15'd0);
    write_register(REG_DECAY, 15'd0);
    cfg_valid <= 1'b0;
    for (int i = 8; i < 16; i++) push_trigger(OPENING[i]);
    drain_samples();
    write_register(REG_PHASE_INC, 15'h7fff);
    write_register(REG_CYCLE_LIMIT, 15'd511);
    write_register(REG_DECAY, 15'd4095);
    cfg_valid <= 1'b0;
    for (int i = 16; i < 24; i++) push_trigger(OPENING[i]);
    drain_samples();

    for (int p = 0; p < 20; p++) begin
      steady <= (p >= 6 && p <= 8);
      shuffle_settings();
      play_triggers($urandom_range(60, 140));
      drain_samples();
    end

    repeat (FLUSH_CYCLES) @(posedge clk);
    if (board.errors == 0 && board.pending() == 0)
      $display("tb_vosim_grain_oscillator: PASS");
    else
      $display("tb_vosim_grain_oscillator: FAIL");
    $finish;
  end

endmodule

@@ sim.f @@
hdl/vgo_pkg.sv
hdl/vosim_grain_oscillator.sv
bench/tb_vosim_grain_oscillator.sv
